// File: src/lbcs_pkg.sv
// shared types and constants for the layered box collision scan
// no dependencies; imported by the box store, the top level, the checker and tb_top
package lbcs_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SLOT_W    = 4;
    localparam int CMD_W     = 2;
    localparam int LAYER_W   = 3;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRC,
        ST_SCAN,
        ST_DONE
    } t_state;

    // one stored box: flags and geometry in a single memory word
    typedef struct packed {
        logic                      en;
        logic                      hdl;
        logic [LAYER_W-1:0]        lsrc;
        logic [LAYER_W-1:0]        ltgt;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_box;

    // slave tdata layout, msb member first
    typedef struct packed {
        logic [5:0]                pad;
        logic [SIZE_W-1:0]         h;
        logic [SIZE_W-1:0]         w;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
        logic [LAYER_W-1:0]        ltgt;
        logic [LAYER_W-1:0]        lsrc;
        logic                      hdl;
        logic                      en;
        logic [SLOT_W-1:0]         slot;
    } t_s_data;

    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } t_store_req;

endpackage

// File: src/lbcs_box_store.sv
// box table: one synchronous memory of t_box words plus a per-slot valid bit
// depends on lbcs_pkg
module lbcs_box_store import lbcs_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_store_req    i_req,
    input  logic [IW-1:0] i_wr_addr,
    input  t_box          i_wr_box,
    input  logic [IW-1:0] i_rd_addr,
    output t_box          o_rd_box,
    output logic          o_rd_valid
);

    t_box             r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_box             r_rd_box;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_wr_addr] <= i_wr_box;
        end
        if (i_req.rd) begin
            r_rd_box   <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // slot presence; remove only drops the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_req.clr) begin
            r_valid[i_wr_addr] <= 1'b0;
        end
    end

    assign o_rd_box   = r_rd_box;
    assign o_rd_valid = r_rd_valid;

endmodule

// File: src/layered_box_collision_scan_top.sv
// layered box collision scan, top level
// depends on lbcs_pkg and lbcs_box_store
//
// slave channel takes commands: tuser holds the command (write, remove, query),
// tdata the slot and box fields. write and remove give no result. a query
// occupies the block while it is accepted, the source box is fetched from the
// box memory, every slot is read once through the single memory read port and
// the final result is handed over; the scan is skipped for an inactive source.
// master channel gives the hits of a query in ascending slot order, tlast on the
// final one; a query without hits gives a single transfer with tuser (hit_valid)
// low and tlast high. results wait in one output register, the latest hit held
// back; if the receiver stalls while that hit and a new hit are ready, the scan
// holds in place and resumes without loss. the slave side is ready only between
// commands. reset empties every slot by clearing the valid bits; geometry is left
// as it is and only used for slots written since.
module layered_box_collision_scan_top import lbcs_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // slot, enabled, has_handler, layer_source, layer_target, center_x, center_y,
    // width, height
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd
    input  logic [CMD_W-1:0]     i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // hit_slot
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // hit_valid
    output logic                 o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    localparam int IW = $clog2(SLOTS);
    localparam int AW = (IW > SLOT_W) ? IW : SLOT_W;

    t_state           r_state, n_state;
    t_s_data          s_data;
    t_cmd             s_cmd;
    t_box             wr_box;
    t_store_req       store_req;
    logic [IW-1:0]    rd_addr;
    t_box             rd_box;
    logic             rd_valid;

    logic [AW-1:0]    slot_ext;
    logic [IW-1:0]    slot_addr;
    logic             slot_in_range;
    logic             s_accept;

    logic [IW-1:0]    r_q_idx;
    logic             r_q_in_range;
    t_box             r_src_box;
    logic [IW-1:0]    r_src_idx;
    logic [IW-1:0]    r_rd_idx;
    logic             r_pend_vld;
    logic [IW-1:0]    r_pend_idx;
    logic             r_out_vld;
    logic [SLOT_W-1:0] r_out_slot;
    logic             r_out_hit;
    logic             r_out_last;

    logic             src_active;
    logic             scan_last;
    logic             hit;
    logic             stall;
    logic             out_blocked;
    logic             push;
    logic [IW-1:0]    push_idx;
    logic             push_hit;
    logic             push_last;
    logic [AW-1:0]    push_ext;

    logic signed [COORD_W:0] dcx, dcy;
    logic [COORD_W:0]        adx, ady;
    logic [COORD_W+1:0]      sum_w, sum_h;
    logic                    ov_x, ov_y;

    assign s_data        = t_s_data'(i_s_axis_tdata);
    assign s_cmd         = t_cmd'(i_s_axis_tuser);
    assign slot_ext      = AW'(s_data.slot);
    assign slot_addr     = slot_ext[IW-1:0];
    assign slot_in_range = {1'b0, slot_ext} < (AW+1)'(SLOTS);
    assign s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        wr_box      = '0;
        wr_box.en   = s_data.en;
        wr_box.hdl  = s_data.hdl;
        wr_box.lsrc = s_data.lsrc;
        wr_box.ltgt = s_data.ltgt;
        wr_box.cx   = s_data.cx;
        wr_box.cy   = s_data.cy;
        wr_box.w    = s_data.w;
        wr_box.h    = s_data.h;
    end

    lbcs_box_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .i_wr_addr  (slot_addr),
        .i_wr_box   (wr_box),
        .i_rd_addr  (rd_addr),
        .o_rd_box   (rd_box),
        .o_rd_valid (rd_valid)
    );

    // source fetched in ST_SRC straight from the memory read register
    assign src_active = r_q_in_range && rd_valid && rd_box.en && (rd_box.ltgt != '0);

    // overlap per axis in doubled coordinates reduces to |c1-c2|*2 <= s1+s2
    assign dcx   = (COORD_W+1)'(r_src_box.cx) - (COORD_W+1)'(rd_box.cx);
    assign dcy   = (COORD_W+1)'(r_src_box.cy) - (COORD_W+1)'(rd_box.cy);
    assign adx   = dcx[COORD_W] ? (COORD_W+1)'(-dcx) : (COORD_W+1)'(dcx);
    assign ady   = dcy[COORD_W] ? (COORD_W+1)'(-dcy) : (COORD_W+1)'(dcy);
    assign sum_w = (COORD_W+2)'(r_src_box.w) + (COORD_W+2)'(rd_box.w);
    assign sum_h = (COORD_W+2)'(r_src_box.h) + (COORD_W+2)'(rd_box.h);
    assign ov_x  = {adx, 1'b0} <= sum_w;
    assign ov_y  = {ady, 1'b0} <= sum_h;

    assign hit = rd_valid && rd_box.en && rd_box.hdl && (r_rd_idx != r_src_idx)
                 && (rd_box.lsrc == r_src_box.ltgt) && ov_x && ov_y;

    assign scan_last   = r_rd_idx == IW'(SLOTS - 1);
    assign out_blocked = r_out_vld && !i_m_axis_tready;
    assign stall       = (r_state == ST_SCAN) && hit && r_pend_vld && out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        store_req       = '0;
        rd_addr         = '0;
        push            = 1'b0;
        push_idx        = r_pend_idx;
        push_hit        = 1'b0;
        push_last       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                rd_addr         = slot_addr;
                if (s_accept) begin
                    case (s_cmd)
                        CMD_WRITE:  store_req.wr  = slot_in_range;
                        CMD_REMOVE: store_req.clr = slot_in_range;
                        CMD_QUERY: begin
                            store_req.rd = 1'b1;
                            n_state      = ST_SRC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRC: begin
                store_req.rd = 1'b1;
                n_state      = src_active ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (!stall) begin
                    store_req.rd = 1'b1;
                    rd_addr      = scan_last ? '0 : r_rd_idx + 1'b1;
                    // a new hit releases the previous one, which is then not last
                    if (hit && r_pend_vld) begin
                        push     = 1'b1;
                        push_hit = 1'b1;
                    end
                    if (scan_last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                push      = 1'b1;
                push_hit  = r_pend_vld;
                push_last = 1'b1;
                if (!r_pend_vld) begin
                    push_idx = '0;
                end
                if (!out_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_q_idx      <= slot_addr;
            r_q_in_range <= slot_in_range;
        end
        if (r_state == ST_SRC) begin
            r_src_box <= rd_box;
            r_src_idx <= r_q_idx;
            r_rd_idx  <= '0;
        end else if (r_state == ST_SCAN && !stall) begin
            r_rd_idx <= r_rd_idx + 1'b1;
            if (hit) begin
                r_pend_idx <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (r_state == ST_SRC) begin
            r_pend_vld <= 1'b0;
        end else if (r_state == ST_SCAN && !stall && hit) begin
            r_pend_vld <= 1'b1;
        end
    end

    assign push_ext = AW'(push_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!out_blocked) begin
            r_out_vld <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_blocked && push) begin
            r_out_slot <= push_ext[SLOT_W-1:0];
            r_out_hit  <= push_hit;
            r_out_last <= push_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_slot);
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tlast  = r_out_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tlast && r_out_slot == '0))
        else $error("empty query result without last or with nonzero slot");

    a_scan_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !stall && !scan_last)
        |=> (r_state == ST_SCAN && r_rd_idx == $past(r_rd_idx) + 1'b1))
        else $error("scan index did not advance");

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> (r_pend_vld && r_out_vld))
        else $error("scan stalled without a pending hit");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !out_blocked) |=> (r_state == ST_IDLE && o_m_axis_tvalid
        && o_m_axis_tlast))
        else $error("final result not issued on leaving done");

endmodule

// File: bench/lbcs_checker.sv
`timescale 1ns / 100ps
// result checker for the layered box collision scan: mirrors the box table from
// accepted commands, predicts the hits of each query and compares result transfers
// depends on lbcs_pkg
module lbcs_checker import lbcs_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // slot, enabled, has_handler, layer_source, layer_target, center_x, center_y,
    // width, height
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // hit_slot
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // hit_valid
    input  logic                 i_m_tuser,
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [M_TDATA_W-1:0] slot_bits;
        logic                 hit;
        logic                 last;
    } t_hit_rec;

    t_box     box_table [SLOTS];
    t_hit_rec expected_hits [$];
    int       mismatches = 0;

    // per axis test in doubled coordinates, touching counts
    function automatic bit spans_touch(input logic signed [COORD_W-1:0] c1,
                                       input logic [SIZE_W-1:0] s1,
                                       input logic signed [COORD_W-1:0] c2,
                                       input logic [SIZE_W-1:0] s2);
        int r1, l1, r2, l2;
        r1 = 2 * int'(c1) + int'(s1);
        l1 = 2 * int'(c1) - int'(s1);
        r2 = 2 * int'(c2) + int'(s2);
        l2 = 2 * int'(c2) - int'(s2);
        return (((r1 > r2) ? r1 : r2) - ((l1 < l2) ? l1 : l2)) <= 2 * (int'(s1) + int'(s2));
    endfunction

    // append one predicted result transfer
    function automatic void expect_result(input logic [M_TDATA_W-1:0] slot_bits,
                                          input logic hit, input logic last);
        t_hit_rec rec;
        rec           = '{slot_bits, hit, last};
        expected_hits = {expected_hits, rec};
    endfunction

    always @(posedge i_clk) begin : track
        t_s_data           item;
        t_box              src;
        t_hit_rec          got;
        t_hit_rec          want;
        logic [SLOT_W-1:0] prev_hit;
        bit                have_hit;
        if (!i_rst_n) begin
            foreach (box_table[i]) box_table[i] = '0;
            expected_hits.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata, i_m_tuser, i_m_tlast};
                if (expected_hits.size() == 0) begin
                    $error("unexpected result transfer: hit_slot %0d hit_valid %0b last %0b",
                           got.slot_bits, got.hit, got.last);
                    mismatches++;
                end else begin
                    want = expected_hits.pop_front();
                    if (got.slot_bits !== want.slot_bits) begin
                        $error("hit_slot: expected %0d, got %0d", want.slot_bits, got.slot_bits);
                        mismatches++;
                    end
                    if (got.hit !== want.hit) begin
                        $error("hit_valid: expected %0b, got %0b", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                item = i_s_tdata;
                case (i_s_tuser)
                    CMD_WRITE: begin
                        if (item.slot < SLOTS) begin
                            box_table[item.slot].en   = item.en;
                            box_table[item.slot].hdl  = item.hdl;
                            box_table[item.slot].lsrc = item.lsrc;
                            box_table[item.slot].ltgt = item.ltgt;
                            box_table[item.slot].cx   = item.cx;
                            box_table[item.slot].cy   = item.cy;
                            box_table[item.slot].w    = item.w;
                            box_table[item.slot].h    = item.h;
                        end
                    end
                    CMD_REMOVE: begin
                        // flags only, geometry stays behind
                        if (item.slot < SLOTS) begin
                            box_table[item.slot].en   = 1'b0;
                            box_table[item.slot].hdl  = 1'b0;
                            box_table[item.slot].lsrc = '0;
                            box_table[item.slot].ltgt = '0;
                        end
                    end
                    CMD_QUERY: begin
                        have_hit = 1'b0;
                        prev_hit = '0;
                        if (item.slot < SLOTS) begin
                            src = box_table[item.slot];
                            if (src.en && src.ltgt != '0) begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (i != item.slot && box_table[i].en && box_table[i].hdl
                                        && box_table[i].lsrc == src.ltgt
                                        && spans_touch(src.cx, src.w, box_table[i].cx,
                                                       box_table[i].w)
                                        && spans_touch(src.cy, src.h, box_table[i].cy,
                                                       box_table[i].h)) begin
                                        // hold back one hit so the final one gets last
                                        if (have_hit)
                                            expect_result(M_TDATA_W'(prev_hit), 1'b1, 1'b0);
                                        prev_hit = SLOT_W'(i);
                                        have_hit = 1'b1;
                                    end
                                end
                            end
                        end
                        if (have_hit)
                            expect_result(M_TDATA_W'(prev_hit), 1'b1, 1'b1);
                        else
                            expect_result('0, 1'b0, 1'b1);
                    end
                    default: ; // unused command code, no effect
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_hits.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench top for layered_box_collision_scan_top: drives commands, paces the
// result channel and reports the verdict; depends on lbcs_pkg, lbcs_checker and the top level
module tb_top;
    import lbcs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SCAN_CYCLES = SLOTS_DEF + 3;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 2000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    t_s_data              s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    logic bus_idle      = 1'b1;
    logic long_hold_req = 1'b0;
    int   fail_count;
    int   pending;

    always #5 clk = ~clk;

    layered_box_collision_scan_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    lbcs_checker #(.SLOTS(SLOTS_DEF)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_s_data box_item(input int slot, input int en, input int hdl,
                                         input int lsrc, input int ltgt, input int cx,
                                         input int cy, input int w, input int h);
        t_s_data d;
        d      = '0;
        d.slot = SLOT_W'(slot);
        d.en   = 1'(en);
        d.hdl  = 1'(hdl);
        d.lsrc = LAYER_W'(lsrc);
        d.ltgt = LAYER_W'(ltgt);
        d.cx   = COORD_W'(cx);
        d.cy   = COORD_W'(cy);
        d.w    = SIZE_W'(w);
        d.h    = SIZE_W'(h);
        return d;
    endfunction

    function automatic t_s_data random_item();
        return box_item($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endfunction

    // boxes packed into a small area so that queries find hits
    function automatic t_s_data cluster_box();
        return box_item($urandom_range(0, 15), int'($urandom_range(0, 9) != 0),
                        int'($urandom_range(0, 9) != 0), $urandom_range(0, 3),
                        $urandom_range(0, 3), $urandom_range(0, 200) - 100,
                        $urandom_range(0, 200) - 100, $urandom_range(0, 150),
                        $urandom_range(0, 150));
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input t_s_data d);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        gap = (bus_idle && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // result side pacing
    initial begin : result_pacing
        int  hold;
        bit  long_done;
        hold      = 0;
        long_done = 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req && !long_done) begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (!bus_idle || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold = idle_len() - 1;
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int count;
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, touching edges, filters, extremes, self, remove
        send_cmd(CMD_QUERY,  box_item(5, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_WRITE,  box_item(0, 1, 1, 1, 2, 0, 0, 10, 10));
        send_cmd(CMD_WRITE,  box_item(1, 1, 1, 2, 0, 10, 0, 10, 0));
        send_cmd(CMD_WRITE,  box_item(2, 1, 1, 2, 3, 11, 0, 12, 10));
        send_cmd(CMD_WRITE,  box_item(3, 1, 1, 2, 2, 11, 0, 11, 10));
        send_cmd(CMD_WRITE,  box_item(4, 1, 0, 2, 2, 0, 0, 4, 4));
        send_cmd(CMD_WRITE,  box_item(5, 0, 1, 2, 2, 0, 0, 4, 4));
        send_cmd(CMD_WRITE,  box_item(6, 1, 1, 3, 2, 0, 0, 4, 4));
        send_cmd(CMD_WRITE,  box_item(7, 1, 1, 2, 2, -32768, 32767, 32767, 32767));
        send_cmd(CMD_QUERY,  box_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_QUERY,  box_item(1, 1, 1, 7, 7, -1, -1, 32767, 32767));
        send_cmd(CMD_QUERY,  box_item(5, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_QUERY,  box_item(9, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_WRITE,  box_item(8, 1, 1, 7, 7, 32767, -32768, 32767, 32767));
        send_cmd(CMD_WRITE,  box_item(9, 1, 1, 7, 7, -32768, 32767, 32767, 32767));
        send_cmd(CMD_WRITE,  box_item(10, 1, 1, 7, 0, 32767, -32768, 0, 0));
        send_cmd(CMD_WRITE,  box_item(15, 1, 1, 7, 7, 32767, -32768, 0, 0));
        send_cmd(CMD_QUERY,  box_item(8, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_QUERY,  box_item(15, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_REMOVE, box_item(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_QUERY,  box_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(CMD_UNUSED, random_item());
        send_cmd(CMD_REMOVE, box_item(8, 1, 1, 7, 7, 0, 0, 0, 0));
        send_cmd(CMD_QUERY,  box_item(15, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // full table on one layer: every query returns fifteen hits, and the
        // result side holds off long enough for the input to back up
        for (int s = 0; s < SLOTS_DEF; s++)
            send_cmd(CMD_WRITE, box_item(s, 1, 1, 4, 4, $urandom_range(0, 40) - 20,
                                         $urandom_range(0, 40) - 20,
                                         $urandom_range(100, 200),
                                         $urandom_range(100, 200)));
        long_hold_req <= 1'b1;
        repeat (3) send_cmd(CMD_QUERY, box_item($urandom_range(0, 15), 0, 0, 0, 0,
                                                0, 0, 0, 0));
        wait_drained();

        // random traffic in phases, the third one without idling
        for (int phase = 0; phase < 4; phase++) begin
            bus_idle <= (phase != 2);
            count = 0;
            while (count < 45) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_cmd(CMD_WRITE, cluster_box());
                else if (r < 45)
                    send_cmd(CMD_WRITE, random_item());
                else if (r < 55)
                    send_cmd(CMD_REMOVE, random_item());
                else if (r < 97)
                    send_cmd(CMD_QUERY, random_item());
                else
                    send_cmd(CMD_UNUSED, random_item());
                if (r < 97)
                    count++;
            end
            wait_drained();
        end

        repeat (2 * SCAN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/lbcs_pkg.sv
src/lbcs_box_store.sv
src/layered_box_collision_scan_top.sv
bench/lbcs_checker.sv
bench/tb_top.sv
